// ===== sv/hsbd_pkg.sv =====
// Shared types, register indexes and reset values for the byte deframer.
`default_nettype none

package hsbd_pkg;

    localparam int FRAME_CAPACITY_DEF = 256;

    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 8;
    localparam int FRAME_LEN_W = 9;
    localparam int CFG_ADDR_W = 3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STUFFING_BYTE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TAIL_FIRST    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TAIL_SECOND   = 3'd4;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hF4;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hF5;
    localparam logic [BYTE_W-1:0] STUFFING_BYTE_RST = 8'hF4;
    localparam logic [BYTE_W-1:0] TAIL_FIRST_RST    = 8'hF4;
    localparam logic [BYTE_W-1:0] TAIL_SECOND_RST   = 8'hFB;

    typedef enum logic [1:0] {
        ST_PENDING    = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_BAD_HEADER = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] stuffing_byte;
        logic [BYTE_W-1:0] tail_first;
        logic [BYTE_W-1:0] tail_second;
    } cfg_t;

    // Lowest field last so that the packed order matches the stream layout
    typedef struct packed {
        logic [FRAME_LEN_W-1:0] frame_bytes;
        logic                   restart;
        logic [BYTE_W-1:0]      write_data;
        logic [INDEX_W-1:0]     write_index;
        logic                   write_enable;
        status_t                status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== sv/hsbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hsbd_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/hsbd_state_store.sv =====
// Deframer state record kept in RAM, with write-to-read forwarding.
`default_nettype none

module hsbd_state_store
    import hsbd_pkg::*;
#(
    parameter int STATE_W = 29
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [STATE_W-1:0] wr_data,
    output logic      [STATE_W-1:0] state
);

    localparam int RAM_ADDR_W = 1;
    localparam logic [RAM_ADDR_W-1:0] STATE_ADDR = '0;

    logic [STATE_W-1:0] ram_q;
    logic [STATE_W-1:0] fwd_reg;
    logic               fwd_hit_reg;
    logic               init_reg;

    // Read every cycle; the registered word misses only the latest write
    hsbd_ram #(
        .WIDTH  (STATE_W),
        .ADDR_W (RAM_ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (STATE_ADDR),
        .wr_data (wr_data),
        .rd_en   (1'b1),
        .rd_addr (STATE_ADDR),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
            init_reg    <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en;
            if (wr_en)
            begin
                init_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_reg <= wr_data;
        end
    end

    // Until the first write the entry reads as the reset record (all zero)
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            state = fwd_reg;
        end
        else if (init_reg)
        begin
            state = ram_q;
        end
        else
        begin
            state = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hsbd_step.sv =====
// Per-byte deframing decision: stuffing, header check, overflow, restart, tail.
`default_nettype none

module hsbd_step
    import hsbd_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF,
    parameter int CNT_W          = $clog2(FRAME_CAPACITY + 1)
) (
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cfg_t              cfg,
    input  wire logic [BYTE_W-1:0] prev_byte,
    input  wire logic [BYTE_W-1:0] cur_byte,
    input  wire logic [CNT_W-1:0]  count,
    output logic      [BYTE_W-1:0] prev_byte_next,
    output logic      [BYTE_W-1:0] cur_byte_next,
    output logic      [CNT_W-1:0]  count_next,
    output result_t                result
);

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(FRAME_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    logic             stuffed_pair;
    logic             bad_header;
    logic             header_pair;
    logic             tail_pair;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] frame_len;
    logic [CNT_W-1:0] write_pos;

    // The byte held as current becomes the previous byte of this step
    assign stuffed_pair = (cur_byte == cfg.stuffing_byte) && (rx_byte == cfg.stuffing_byte);
    assign bad_header   = ((count == CNT_ZERO) && (rx_byte != cfg.header_first)) ||
                          ((count == CNT_ONE) && (rx_byte != cfg.header_second));
    assign header_pair  = (cur_byte == cfg.header_first) && (rx_byte == cfg.header_second);
    assign tail_pair    = (cur_byte == cfg.tail_first) && (rx_byte == cfg.tail_second);
    assign count_inc    = count + CNT_ONE;
    assign frame_len    = header_pair ? CNT_TWO : count_inc;
    assign write_pos    = header_pair ? CNT_ONE : count;

    always_comb
    begin
        result         = '0;
        result.status  = ST_PENDING;
        prev_byte_next = cur_byte;
        cur_byte_next  = rx_byte;
        count_next     = count;

        if (stuffed_pair)
        begin
            // Drop the second stuffing byte
            cur_byte_next      = '0;
            result.frame_bytes = FRAME_LEN_W'(count);
        end
        else if (bad_header)
        begin
            prev_byte_next     = '0;
            cur_byte_next      = '0;
            result.status      = ST_BAD_HEADER;
            result.frame_bytes = FRAME_LEN_W'(count);
        end
        else if (count >= CAPACITY)
        begin
            prev_byte_next = '0;
            cur_byte_next  = '0;
            count_next     = '0;
            result.status  = ST_OVERFLOW;
        end
        else
        begin
            result.write_enable = 1'b1;
            result.write_index  = INDEX_W'(write_pos);
            result.write_data   = rx_byte;
            result.restart      = header_pair;
            result.frame_bytes  = FRAME_LEN_W'(frame_len);
            count_next          = frame_len;
            if (tail_pair)
            begin
                result.status = ST_COMPLETE;
                count_next    = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/hsbd_skid.sv =====
// Output register with one skid entry so one more input beat is taken under stall.
`default_nettype none

module hsbd_skid
    import hsbd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_load;
    logic    in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_load = out_ready || !out_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_load)
        begin
            out_valid_next  = skid_valid_reg || in_fire;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/header_synced_byte_deframer_core.sv =====
// Top level of the header-synced byte deframer with stuffing-byte collapse.
//
//  Channel  Dir  Beat payload
//  s_axis   in   tdata[7:0] rx_byte
//  m_axis   out  tdata[28:0] status, write_enable, write_index, write_data,
//                restart, frame_bytes (one beat per input beat)
//  cfg      in   cfg_wr_en / cfg_addr / cfg_data, one register per write
//
//  One byte per cycle sustained while m_axis accepts; the decision is combinational from state to result.
//  State (previous byte, current byte, length) lives in one entry of a two-entry RAM; the word
//  written on one edge is forwarded to the next cycle over the RAM read latency.
//  Reset clears the state record and loads the register defaults; no clearing pass.
//  A stalled m_axis holds up to two results (output register plus skid entry)
//  before s_tready drops.
`default_nettype none

module header_synced_byte_deframer_core
    import hsbd_pkg::*;
#(
    parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [1:0] status, [2] write_enable, [10:3] write_index, [18:11] write_data,
    // [19] restart, [28:20] frame_bytes, [31:29] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [BYTE_W-1:0]      cfg_data
);

    localparam int CNT_W   = $clog2(FRAME_CAPACITY + 1);
    localparam int STATE_W = 2 * BYTE_W + CNT_W;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    in_fire;

    logic [STATE_W-1:0] state;
    logic [STATE_W-1:0] state_next;
    logic [BYTE_W-1:0]  prev_byte;
    logic [BYTE_W-1:0]  cur_byte;
    logic [CNT_W-1:0]   count;
    logic [BYTE_W-1:0]  prev_byte_next;
    logic [BYTE_W-1:0]  cur_byte_next;
    logic [CNT_W-1:0]   count_next;
    result_t            step_result;
    result_t            out_result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                REG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                REG_STUFFING_BYTE: cfg_next.stuffing_byte = cfg_data;
                REG_TAIL_FIRST:    cfg_next.tail_first    = cfg_data;
                REG_TAIL_SECOND:   cfg_next.tail_second   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.stuffing_byte <= STUFFING_BYTE_RST;
            cfg_reg.tail_first    <= TAIL_FIRST_RST;
            cfg_reg.tail_second   <= TAIL_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_fire = s_tvalid && s_tready;

    hsbd_state_store #(
        .STATE_W (STATE_W)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_fire),
        .wr_data (state_next),
        .state   (state)
    );

    assign {count, cur_byte, prev_byte} = state;
    assign state_next = {count_next, cur_byte_next, prev_byte_next};

    hsbd_step #(
        .FRAME_CAPACITY (FRAME_CAPACITY),
        .CNT_W          (CNT_W)
    ) u_step (
        .rx_byte        (s_tdata),
        .cfg            (cfg_reg),
        .prev_byte      (prev_byte),
        .cur_byte       (cur_byte),
        .count          (count),
        .prev_byte_next (prev_byte_next),
        .cur_byte_next  (cur_byte_next),
        .count_next     (count_next),
        .result         (step_result)
    );

    hsbd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = OUT_TDATA_W'(out_result);

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the header-synced byte deframer core.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import hsbd_pkg::*;

    localparam int FRAME_CAPACITY = FRAME_CAPACITY_DEF;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_BYTES    = 72;
    localparam int MAX_REPORTS    = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;

    header_synced_byte_deframer_core #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies and deframer state mirrored by the predictor
    logic [BYTE_W-1:0] hdr_first_q   = HEADER_FIRST_RST;
    logic [BYTE_W-1:0] hdr_second_q  = HEADER_SECOND_RST;
    logic [BYTE_W-1:0] stuff_byte_q  = STUFFING_BYTE_RST;
    logic [BYTE_W-1:0] tail_first_q  = TAIL_FIRST_RST;
    logic [BYTE_W-1:0] tail_second_q = TAIL_SECOND_RST;
    logic [BYTE_W-1:0] last_rx_q     = '0;
    logic [BYTE_W-1:0] this_rx_q     = '0;
    int                frame_len_q   = 0;

    logic [BYTE_W-1:0] rx_backlog [$];
    result_t           pending_results [$];
    logic [BYTE_W-1:0] opening_bytes [0:20];

    int  bytes_queued = 0;
    int  bytes_taken = 0;
    int  results_checked = 0;
    int  frames_done = 0;
    int  overflows = 0;
    int  restarts = 0;
    int  bad_headers = 0;
    int  collapses = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic input_taken = 1'b0;

    function automatic result_t deframe_byte(input logic [BYTE_W-1:0] rx);
        result_t r;
        int      idx;
        r = '0;
        last_rx_q = this_rx_q;
        this_rx_q = rx;
        // Collapse a doubled stuffing byte
        if (last_rx_q == stuff_byte_q && this_rx_q == stuff_byte_q) begin
            this_rx_q = '0;
            r.frame_bytes = frame_len_q[FRAME_LEN_W-1:0];
            return r;
        end
        if ((frame_len_q == 0 && this_rx_q != hdr_first_q) ||
            (frame_len_q == 1 && this_rx_q != hdr_second_q)) begin
            last_rx_q = '0;
            this_rx_q = '0;
            r.status = ST_BAD_HEADER;
            r.frame_bytes = frame_len_q[FRAME_LEN_W-1:0];
            return r;
        end
        if (frame_len_q >= FRAME_CAPACITY) begin
            last_rx_q = '0;
            this_rx_q = '0;
            frame_len_q = 0;
            r.status = ST_OVERFLOW;
            return r;
        end
        idx = frame_len_q;
        frame_len_q = frame_len_q + 1;
        if (last_rx_q == hdr_first_q && this_rx_q == hdr_second_q) begin
            r.restart = 1'b1;
            idx = 1;
            frame_len_q = 2;
        end
        r.frame_bytes = frame_len_q[FRAME_LEN_W-1:0];
        if (last_rx_q == tail_first_q && this_rx_q == tail_second_q) begin
            r.status = ST_COMPLETE;
            frame_len_q = 0;
        end
        r.write_enable = 1'b1;
        r.write_index = idx[INDEX_W-1:0];
        r.write_data = this_rx_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Drive inputs on the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || input_taken) begin
            if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata  <= rx_backlog.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sample beats on the rising edge, predict and check
    always @(posedge clk)
    begin : monitor_blk
        result_t got;
        result_t want;
        if (!rst_n)
            input_taken <= 1'b0;
        else begin
            input_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                pending_results.push_back(deframe_byte(s_tdata));
                bytes_taken++;
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing pending", 1, 0);
                else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.write_enable != want.write_enable)
                        report_mismatch("write_enable", got.write_enable, want.write_enable);
                    if (got.write_index != want.write_index)
                        report_mismatch("write_index", got.write_index, want.write_index);
                    if (got.write_data != want.write_data)
                        report_mismatch("write_data", got.write_data, want.write_data);
                    if (got.restart != want.restart)
                        report_mismatch("restart", got.restart, want.restart);
                    if (got.frame_bytes != want.frame_bytes)
                        report_mismatch("frame_bytes", got.frame_bytes, want.frame_bytes);
                    case (want.status)
                        ST_COMPLETE:   frames_done++;
                        ST_OVERFLOW:   overflows++;
                        ST_BAD_HEADER: bad_headers++;
                        default:       if (!want.write_enable) collapses++;
                    endcase
                    if (want.restart)
                        restarts++;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved in %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    // Hold until every queued byte is taken and every result has come back
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        case (idx)
            REG_HEADER_FIRST:  hdr_first_q = val;
            REG_HEADER_SECOND: hdr_second_q = val;
            REG_STUFFING_BYTE: stuff_byte_q = val;
            REG_TAIL_FIRST:    tail_first_q = val;
            REG_TAIL_SECOND:   tail_second_q = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_regs(input logic [BYTE_W-1:0] hf, input logic [BYTE_W-1:0] hs,
                             input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] tf,
                             input logic [BYTE_W-1:0] ts);
        write_reg(REG_HEADER_FIRST, hf);
        write_reg(REG_HEADER_SECOND, hs);
        write_reg(REG_STUFFING_BYTE, sb);
        write_reg(REG_TAIL_FIRST, tf);
        write_reg(REG_TAIL_SECOND, ts);
    endtask

    // Payload bytes lean on the marker values so stuffing, restarts and tails show up
    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return hdr_first_q;
            1:       return hdr_second_q;
            2:       return stuff_byte_q;
            3:       return tail_first_q;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int payload_len);
        send_byte(hdr_first_q);
        send_byte(hdr_second_q);
        for (int i = 0; i < payload_len; i++)
            send_byte(payload_byte());
        send_byte(tail_first_q);
        send_byte(tail_second_q);
    endtask

    // Plain random payload so the length is not cut short by restarts or tails
    task automatic send_long_frame(input int payload_len);
        send_byte(hdr_first_q);
        send_byte(hdr_second_q);
        for (int i = 0; i < payload_len; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(tail_first_q);
        send_byte(tail_second_q);
    endtask

    task automatic send_traffic(input int target);
        int start;
        int pick;
        start = bytes_queued;
        while (bytes_queued - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_frame($urandom_range(0, 20));
            else if (pick < 84) begin
                repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            else if (pick < 92) begin
                // Header pair again in mid-frame
                send_byte(hdr_first_q);
                send_byte(hdr_second_q);
                repeat ($urandom_range(0, 6)) send_byte(payload_byte());
                send_byte(hdr_first_q);
                send_byte(hdr_second_q);
                repeat ($urandom_range(0, 6)) send_byte(payload_byte());
                send_byte(tail_first_q);
                send_byte(tail_second_q);
            end
            else begin
                // Broken header: right first byte, wrong second
                send_byte(hdr_first_q);
                send_byte(hdr_second_q ^ BYTE_W'($urandom_range(1, 255)));
            end
        end
    endtask

    initial
    begin
        int sel;
        opening_bytes = '{8'h00, 8'hFF, HEADER_FIRST_RST, 8'h12, HEADER_SECOND_RST,
                          8'h00, 8'hFF, STUFFING_BYTE_RST, STUFFING_BYTE_RST,
                          HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h55,
                          TAIL_FIRST_RST, TAIL_SECOND_RST,
                          HEADER_FIRST_RST, HEADER_SECOND_RST, 8'hAA, 8'h80, 8'h01,
                          TAIL_FIRST_RST, TAIL_SECOND_RST};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values: bad header bytes, stuffing, restart, tail
        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            sel = p % 4;
            send_idle_pct  = (sel == 1 || sel == 3) ? ((sel == 1) ? 84 : 23) : 0;
            recv_stall_pct = (sel == 2 || sel == 3) ? ((sel == 2) ? 84 : 23) : 0;
            case (p)
                1: load_regs('0, '0, '0, '0, '0);
                2: load_regs('1, '1, '1, '1, '1);
                3, 5, 7: load_regs(BYTE_W'($urandom_range(0, 255)),
                                   BYTE_W'($urandom_range(0, 255)),
                                   BYTE_W'($urandom_range(0, 255)),
                                   BYTE_W'($urandom_range(0, 255)),
                                   BYTE_W'($urandom_range(0, 255)));
                4: begin
                    // Tail pair equals header pair: restart and complete together
                    sel = $urandom_range(0, 255);
                    load_regs(BYTE_W'(sel), BYTE_W'(sel + 1), BYTE_W'(sel + 2),
                              BYTE_W'(sel), BYTE_W'(sel + 1));
                end
                6: load_regs(HEADER_FIRST_RST, HEADER_SECOND_RST, STUFFING_BYTE_RST,
                             TAIL_FIRST_RST, TAIL_SECOND_RST);
                default: ;
            endcase
            send_traffic(PHASE_BYTES / 2);
            wait_drained();
            // Run past capacity in a few phases
            if (p % 3 == 0)
                send_long_frame($urandom_range(254, 258));
            send_traffic(PHASE_BYTES / 2);
            wait_drained();
        end

        repeat (10) @(negedge clk);
        $display("checked %0d results from %0d bytes over %0d register settings",
                 results_checked, bytes_taken, PHASES);
        $display("complete %0d, overflow %0d, restart %0d, bad header %0d, collapsed %0d",
                 frames_done, overflows, restarts, bad_headers, collapses);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
